// ===== hdl/ergf_pkg.sv =====
// Package: shared widths, types and register codes of the encoder rollover glitch filter.
`timescale 1ns / 1ps

package ergf_pkg;

   localparam int POS_W        = 14;
   localparam int CNT_W        = 32;
   localparam int WINDOW_DEPTH = 4;
   localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
   localparam int CSR_IDX_W    = 2;

   localparam logic [POS_W-1:0] SECOND_MIN_RESET = POS_W'(13000);
   localparam logic [POS_W-1:0] THIRD_MIN_RESET  = POS_W'(15000);
   localparam logic [POS_W-1:0] NEWEST_MIN_RESET = POS_W'(2000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SECOND_MIN = 2'd0,
      CSR_THIRD_MIN  = 2'd1,
      CSR_NEWEST_MIN = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_CLEAR  = 1'b1
   } command_type;

   // window[0] is the oldest sample, window[WINDOW_DEPTH-1] the newest
   typedef logic [WINDOW_DEPTH-1:0][POS_W-1:0] win_type;

   typedef struct packed {
      logic [POS_W-1:0] second_min;
      logic [POS_W-1:0] third_min;
      logic [POS_W-1:0] newest_min;
   } thresh_type;

   typedef struct packed {
      logic             fix;
      logic [POS_W-1:0] value;
   } check_type;

endpackage

// ===== hdl/ergf_if.sv =====
// Interfaces: request, response and register write channels of the glitch filter.
`timescale 1ns / 1ps

interface ergf_req_if;
   import ergf_pkg::*;
   logic             valid;
   logic             ready;
   logic             command;
   logic [POS_W-1:0] position;

   modport source (output valid, command, position, input ready);
   modport sink   (input valid, command, position, output ready);
endinterface

interface ergf_rsp_if;
   import ergf_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] filtered_position;
   logic             corrected;
   logic [CNT_W-1:0] sample_count;
   logic [CNT_W-1:0] correction_count;

   modport source (output valid, filtered_position, corrected, sample_count,
                   correction_count, input ready);
   modport sink   (input valid, filtered_position, corrected, sample_count,
                   correction_count, output ready);
endinterface

interface ergf_csr_if;
   import ergf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [POS_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ergf_check.sv =====
// Rollover pattern check and extrapolated replacement for the shifted sample window.
`timescale 1ns / 1ps

module ergf_check
   import ergf_pkg::*;
(
   input  win_type    win,
   input  logic       full,
   input  thresh_type thr,
   output check_type  res
);

   logic [POS_W-1:0] p0, p1, p2, p3;
   logic [POS_W-1:0] delta_01, delta_12;
   logic [POS_W:0]   delta_sum;
   logic [POS_W-1:0] avg;
   logic             pattern;

   assign p0 = win[0];
   assign p1 = win[1];
   assign p2 = win[2];
   assign p3 = win[3];

   // Modular deltas over the position range wrap naturally in POS_W bits
   assign delta_01  = p1 - p0;
   assign delta_12  = p2 - p1;
   assign delta_sum = {1'b0, delta_01} + {1'b0, delta_12};
   assign avg       = delta_sum[POS_W:1];

   assign pattern = (p1 > p0) && (p2 > p1) && (p3 < p2) &&
                    (p1 > thr.second_min) && (p2 > thr.third_min) &&
                    (p3 > thr.newest_min);

   always_comb begin
      res.fix   = full && pattern;
      res.value = res.fix ? (p2 + avg) : p3;
   end

endmodule

// ===== hdl/encoder_rollover_glitch_filter.sv =====
// Top level: encoder rollover glitch filter with window, counters and register port.
//
//   channel   direction  transfer when         payload
//   req       in         valid && ready        command, position
//   rsp       out        valid && ready        filtered_position, corrected, counts
//   csr       in         valid && ready        index, data (always ready)
//
// One item per cycle while rsp does not stall; a req transfer goes through the input
// register, then the check and the window/counter update into the result register,
// which drives rsp valid.
// The window update is combinational and registered with the result, so a sample sees
// the window left by the one before it. A stalled rsp holds the result; req keeps
// flowing until the input register is also full. Synchronous reset clears window,
// fill level, counters and thresholds to their reset values.
`timescale 1ns / 1ps

module encoder_rollover_glitch_filter
   import ergf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ergf_req_if.sink   req,
   ergf_rsp_if.source rsp,
   ergf_csr_if.sink   csr
);

   thresh_type       thr_ff;
   win_type          win_ff, win_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] samples_ff, samples_in;
   logic [CNT_W-1:0] anomalies_ff, anomalies_in;

   logic             s1_valid_ff;
   logic             s1_command_ff;
   logic [POS_W-1:0] s1_position_ff;

   logic             out_valid_ff;
   logic [POS_W-1:0] out_pos_ff, out_pos_in;
   logic             out_fix_ff, out_fix_in;
   logic [CNT_W-1:0] out_samples_ff;
   logic [CNT_W-1:0] out_anomalies_ff;

   logic             advance;
   logic             s1_move;
   logic             is_clear;
   logic             full;
   win_type          shifted;
   check_type        chk;

   // register port
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.second_min <= SECOND_MIN_RESET;
         thr_ff.third_min  <= THIRD_MIN_RESET;
         thr_ff.newest_min <= NEWEST_MIN_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_SECOND_MIN: thr_ff.second_min <= csr.data;
            CSR_THIRD_MIN:  thr_ff.third_min  <= csr.data;
            CSR_NEWEST_MIN: thr_ff.newest_min <= csr.data;
            default: ;
         endcase
      end
   end

   // handshake
   assign advance   = !out_valid_ff || rsp.ready;
   assign s1_move   = s1_valid_ff && advance;
   assign req.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_command_ff  <= req.command;
         s1_position_ff <= req.position;
      end
   end

   // window shift and check
   assign is_clear = (s1_command_ff == CMD_CLEAR);

   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
         shifted[i] = win_ff[i+1];
      end
      shifted[WINDOW_DEPTH-1] = s1_position_ff;
   end

   assign full = (fill_ff >= FILL_W'(WINDOW_DEPTH - 1));

   ergf_check u_check (
      .win  (shifted),
      .full (full),
      .thr  (thr_ff),
      .res  (chk)
   );

   always_comb begin
      win_in       = win_ff;
      fill_in      = fill_ff;
      samples_in   = samples_ff;
      anomalies_in = anomalies_ff;
      out_pos_in   = win_ff[WINDOW_DEPTH-1];
      out_fix_in   = 1'b0;
      if (s1_move) begin
         if (is_clear) begin
            samples_in   = '0;
            anomalies_in = '0;
         end else begin
            win_in                 = shifted;
            win_in[WINDOW_DEPTH-1] = chk.value;
            if (fill_ff < FILL_W'(WINDOW_DEPTH)) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            samples_in   = samples_ff + CNT_W'(1);
            anomalies_in = anomalies_ff + CNT_W'(chk.fix);
            out_pos_in   = chk.value;
            out_fix_in   = chk.fix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         fill_ff      <= '0;
         samples_ff   <= '0;
         anomalies_ff <= '0;
      end else begin
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         samples_ff   <= samples_in;
         anomalies_ff <= anomalies_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_pos_ff       <= out_pos_in;
         out_fix_ff       <= out_fix_in;
         out_samples_ff   <= samples_in;
         out_anomalies_ff <= anomalies_in;
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.filtered_position = out_pos_ff;
   assign rsp.corrected         = out_fix_ff;
   assign rsp.sample_count      = out_samples_ff;
   assign rsp.correction_count  = out_anomalies_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_DEPTH))
      else $error("fill level beyond window depth");

   a_fix_needs_full: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_fix_ff) |-> (fill_ff == FILL_W'(WINDOW_DEPTH)))
      else $error("correction reported before window filled");

   a_sample_count: assert property (@(posedge clock) disable iff (reset)
      (s1_move && !is_clear) |=> (samples_ff == $past(samples_ff) + CNT_W'(1)))
      else $error("sample counter did not advance");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_move && is_clear) |=> (out_samples_ff == '0 && out_anomalies_ff == '0
                                 && !out_fix_ff))
      else $error("clear result carries nonzero counts");

endmodule

// ===== test/tb.sv =====
// Testbench: random and directed checks of the encoder rollover glitch filter.
`timescale 1ns / 1ps

module tb
   import ergf_pkg::*;
;

   typedef struct {
      logic [POS_W-1:0] position;
      logic             corrected;
      logic [CNT_W-1:0] sample_count;
      logic [CNT_W-1:0] correction_count;
   } filter_output_type;

   typedef struct {
      command_type      command;
      logic [POS_W-1:0] position;
   } sensor_item_type;

   class filter_scoreboard;
      thresh_type        limits;
      win_type           window;
      logic [FILL_W-1:0] fill;
      logic [CNT_W-1:0]  sample_total;
      logic [CNT_W-1:0]  fix_total;
      filter_output_type outputs_due[$];
      int                mismatch_count;

      function new();
         limits.second_min = SECOND_MIN_RESET;
         limits.third_min  = THIRD_MIN_RESET;
         limits.newest_min = NEWEST_MIN_RESET;
         window         = '0;
         fill           = '0;
         sample_total   = '0;
         fix_total      = '0;
         mismatch_count = 0;
      endfunction

      function void set_limit(csr_index_type idx, logic [POS_W-1:0] value);
         case (idx)
            CSR_SECOND_MIN: limits.second_min = value;
            CSR_THIRD_MIN:  limits.third_min  = value;
            CSR_NEWEST_MIN: limits.newest_min = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return outputs_due.size();
      endfunction

      // Advance the window and counters by one transfer and queue the output it yields.
      function void note_transfer(command_type cmd, logic [POS_W-1:0] pos);
         filter_output_type due;
         logic [POS_W-1:0]  rise_a;
         logic [POS_W-1:0]  rise_b;
         logic [POS_W:0]    span;
         logic              fix;
         fix = 1'b0;
         if (cmd == CMD_CLEAR) begin
            sample_total = '0;
            fix_total    = '0;
         end else begin
            sample_total++;
            for (int i = 0; i < WINDOW_DEPTH - 1; i++)
               window[i] = window[i+1];
            window[WINDOW_DEPTH-1] = pos;
            if (fill < WINDOW_DEPTH)
               fill++;
            if (fill == WINDOW_DEPTH && window[1] > window[0] && window[2] > window[1] &&
                window[3] < window[2] && window[1] > limits.second_min &&
                window[2] > limits.third_min && window[3] > limits.newest_min) begin
               // 14-bit wrap of the difference is the modular delta
               rise_a    = window[1] - window[0];
               rise_b    = window[2] - window[1];
               span      = {1'b0, rise_a} + {1'b0, rise_b};
               window[3] = window[2] + span[POS_W:1];
               fix_total++;
               fix = 1'b1;
            end
         end
         due.position         = window[WINDOW_DEPTH-1];
         due.corrected        = fix;
         due.sample_count     = sample_total;
         due.correction_count = fix_total;
         outputs_due.push_back(due);
      endfunction

      function void report(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      endfunction

      function void check_output(logic [POS_W-1:0] pos, logic corr,
                                 logic [CNT_W-1:0] samples, logic [CNT_W-1:0] fixes);
         filter_output_type due;
         if (outputs_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("output with none pending: position %0d corrected %0d", pos, corr);
            return;
         end
         due = outputs_due.pop_front();
         if (pos !== due.position)
            report("filtered_position", CNT_W'(due.position), CNT_W'(pos));
         if (corr !== due.corrected)
            report("corrected", CNT_W'(due.corrected), CNT_W'(corr));
         if (samples !== due.sample_count)
            report("sample_count", due.sample_count, samples);
         if (fixes !== due.correction_count)
            report("correction_count", due.correction_count, fixes);
      endfunction
   endclass

   localparam int unsigned POS_MAX     = (1 << POS_W) - 1;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          LONG_HOLD   = 60;
   localparam int          PHASE_ITEMS = 205;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ergf_req_if req_bus ();
   ergf_rsp_if rsp_bus ();
   ergf_csr_if csr_bus ();

   encoder_rollover_glitch_filter DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   filter_scoreboard sb;
   sensor_item_type  sensor_items[$];
   int               src_idle_pct  = 0;
   int               sink_idle_pct = 0;
   bit               long_hold_req = 1'b0;
   int unsigned      cycle_count   = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_output(rsp_bus.filtered_position, rsp_bus.corrected,
                         rsp_bus.sample_count, rsp_bus.correction_count);
   end

   // Receiver: random stalls, plus one long hold-off when requested.
   initial begin
      int hold_left;
      hold_left   = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   task automatic transfer_item(command_type cmd, logic [POS_W-1:0] pos);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.position <= pos;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_transfer(cmd, pos);
   endtask

   // Hold the sender until every pending output has been taken.
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_limits(logic [POS_W-1:0] second, logic [POS_W-1:0] third,
                               logic [POS_W-1:0] newest);
      csr_index_type    order [3];
      logic [POS_W-1:0] values [3];
      order  = '{CSR_SECOND_MIN, CSR_THIRD_MIN, CSR_NEWEST_MIN};
      values = '{second, third, newest};
      for (int i = 0; i < 3; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= order[i];
         csr_bus.data  <= values[i];
         do @(posedge clock); while (!csr_bus.ready);
         sb.set_limit(order[i], values[i]);
      end
      csr_bus.valid <= 1'b0;
   endtask

   function automatic void queue_item(command_type cmd, int unsigned pos);
      sensor_item_type item;
      item.command  = cmd;
      item.position = pos[POS_W-1:0];
      sensor_items.push_back(item);
   endfunction

   // Mostly rollover-shaped bursts of four, some broken, plus ramps, noise and clears.
   task automatic queue_random_traffic(int count);
      int unsigned burst [4];
      int unsigned s, t, n, lo, pick, ramp_len, step;
      logic [POS_W-1:0] ramp;
      s = 32'(sb.limits.second_min);
      t = 32'(sb.limits.third_min);
      n = 32'(sb.limits.newest_min);
      while (sensor_items.size() < count) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            queue_item(CMD_CLEAR, $urandom_range(POS_MAX));
         end else if (pick < 65) begin
            for (int i = 0; i < 4; i++)
               burst[i] = $urandom_range(POS_MAX);
            if (s < POS_MAX - 1) begin
               burst[1] = $urandom_range(POS_MAX - 1, s + 1);
               lo       = ((burst[1] > t) ? burst[1] : t) + 1;
               if (lo <= POS_MAX) begin
                  burst[2] = $urandom_range(POS_MAX, lo);
                  burst[0] = $urandom_range(burst[1] - 1, 0);
                  if (n + 1 < burst[2])
                     burst[3] = $urandom_range(burst[2] - 1, n + 1);
               end
            end
            if ($urandom_range(4) == 0) begin
               case ($urandom_range(3))
                  0: burst[1] = s;
                  1: burst[3] = n;
                  2: burst[3] = burst[2];
                  default: burst[$urandom_range(3)] = $urandom_range(POS_MAX);
               endcase
            end
            for (int i = 0; i < 4; i++)
               queue_item(CMD_SAMPLE, burst[i]);
         end else if (pick < 85) begin
            ramp     = POS_W'($urandom_range(POS_MAX));
            step     = $urandom_range(400);
            ramp_len = $urandom_range(12, 4);
            for (int i = 0; i < ramp_len; i++) begin
               queue_item(CMD_SAMPLE, 32'(ramp));
               ramp = ramp + POS_W'(step);
            end
         end else begin
            queue_item(CMD_SAMPLE, $urandom_range(POS_MAX));
         end
      end
   endtask

   initial begin
      sensor_item_type item;
      req_bus.valid    = 1'b0;
      req_bus.command  = CMD_SAMPLE;
      req_bus.position = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_SECOND_MIN;
      csr_bus.data     = '0;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      src_idle_pct  = 9;
      sink_idle_pct = 79;
      // clear on an empty window, fill with the field extremes
      transfer_item(CMD_CLEAR, 14'd0);
      transfer_item(CMD_SAMPLE, 14'd0);
      transfer_item(CMD_SAMPLE, 14'(POS_MAX));
      // textbook rollover: corrected to the extrapolated value
      transfer_item(CMD_SAMPLE, 14'd12000);
      transfer_item(CMD_SAMPLE, 14'd14000);
      transfer_item(CMD_SAMPLE, 14'd16000);
      transfer_item(CMD_SAMPLE, 14'd3000);
      // second sample exactly at its minimum: no correction
      transfer_item(CMD_SAMPLE, 14'd100);
      transfer_item(CMD_SAMPLE, 14'd13000);
      transfer_item(CMD_SAMPLE, 14'd16000);
      transfer_item(CMD_SAMPLE, 14'd2500);
      // just above every minimum, odd delta sum truncated
      transfer_item(CMD_SAMPLE, 14'd100);
      transfer_item(CMD_SAMPLE, 14'd13001);
      transfer_item(CMD_SAMPLE, 14'd15001);
      transfer_item(CMD_SAMPLE, 14'd2001);
      // newest at its minimum, then a newest sample above the one before it
      transfer_item(CMD_SAMPLE, 14'd14000);
      transfer_item(CMD_SAMPLE, 14'd16000);
      transfer_item(CMD_SAMPLE, 14'd2000);
      transfer_item(CMD_SAMPLE, 14'd16000);
      // clear keeps the window; extrapolation wraps past the top
      transfer_item(CMD_CLEAR, 14'(POS_MAX));
      transfer_item(CMD_SAMPLE, 14'd16381);
      transfer_item(CMD_SAMPLE, 14'd16382);
      transfer_item(CMD_SAMPLE, 14'd16383);
      transfer_item(CMD_SAMPLE, 14'd16382);
      transfer_item(CMD_SAMPLE, 14'd5000);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_limits(SECOND_MIN_RESET, THIRD_MIN_RESET, NEWEST_MIN_RESET);
            1: write_limits('0, '0, '0);
            2: write_limits(14'(POS_MAX), 14'(POS_MAX), 14'(POS_MAX));
            3: write_limits(POS_W'($urandom_range(POS_MAX)), POS_W'($urandom_range(POS_MAX)),
                            POS_W'($urandom_range(POS_MAX)));
            4: write_limits(POS_W'($urandom_range(8000)), POS_W'($urandom_range(8000)),
                            POS_W'($urandom_range(8000)));
            default: write_limits(POS_W'($urandom_range(16000, 8000)),
                                  POS_W'($urandom_range(16300, 8000)),
                                  POS_W'($urandom_range(POS_MAX)));
         endcase
         if (phase < 2) begin
            src_idle_pct  = 9;
            sink_idle_pct = 79;
         end else if (phase < 4) begin
            src_idle_pct  = 79;
            sink_idle_pct = 9;
         end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
         end
         // back up the result path so the input side stalls
         if (phase == 1 || phase == 4)
            long_hold_req = 1'b1;
         queue_random_traffic(PHASE_ITEMS);
         while (sensor_items.size() > 0) begin
            item = sensor_items.pop_front();
            transfer_item(item.command, item.position);
            if (sensor_items.size() == PHASE_ITEMS / 2)
               drain();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule
